### hdl/olist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_pkg
// Shared sizes, codes and word types for the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;

  // list capacity (2 to 64) and the widths that follow from it
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths of the request and result words
  localparam int OP_W   = 3;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int FPOS_W = 6;
  localparam int ECNT_W = 7;

  // width used when comparing a position against the count
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_GET    = 3'd2,
    OP_FIND   = 3'd3,
    OP_UPDATE = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // request word as accepted
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  // result word handed to the output register
  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [FPOS_W-1:0]       found_position;
    logic [ECNT_W-1:0]       element_count;
  } res_t;

  // sequencer handshake towards the top level
  typedef struct packed {
    logic idle;
    logic done;
  } seq_flags_t;

endpackage

### hdl/ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values with insert, remove, get, find,
// update and clear, kept in one simple dual-port memory.
//
//   channel  | handshake             | words
//   ---------+-----------------------+-------------------------------------
//   request  | req_valid, req_stall  | op, position, value
//   response | rsp_valid, rsp_stall  | status, read_value, found_position,
//            |                       | element_count
//
// One request at a time. Insert at p moves entries p..last up one, then
// writes the value (an append writes at once); remove moves entries above
// p down one; find scans from entry 0 to the first hit or the end. Walks
// move one entry a cycle on the RAM's single read and single write port.
// Reset empties the list (count to zero); the memory is not cleared.
// The response register holds a result under rsp_stall while the next
// request is accepted and worked; its result then waits in the sequencer.
// ----------------------------------------------------------------------------
module ordered_list_engine import olist_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // request
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic [OP_W-1:0]         op,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  // response
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output logic [STAT_W-1:0]       status,
  output logic signed [VAL_W-1:0] read_value,
  output logic [FPOS_W-1:0]       found_position,
  output logic [ECNT_W-1:0]       element_count
);

  req_t       req;
  res_t       rslt;
  seq_flags_t flags;
  logic       start;
  logic       take;

  assign req.op       = op;
  assign req.position = position;
  assign req.value    = value;

  assign req_stall = !flags.idle;
  assign start     = req_valid && !req_stall;
  // result moves into the response register when it is empty or draining
  assign take      = flags.done && (!rsp_valid || !rsp_stall);

  olist_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .take  (take),
    .flags (flags),
    .rslt  (rslt)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status         <= rslt.status;
      read_value     <= rslt.read_value;
      found_position <= rslt.found_position;
      element_count  <= rslt.element_count;
    end
  end

  // an accepted request keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    start |=> req_stall
  ) else $error("request port open right after an accept");

  // the count never runs past the capacity
  a_count_bound: assert property (
    @(posedge clk) disable iff (rst)
    rsp_valid |-> (element_count <= ECNT_W'(CAPACITY))
  ) else $error("element count above capacity");

  // a full status only ever comes with a full list
  a_full_count: assert property (
    @(posedge clk) disable iff (rst)
    (rsp_valid && (status == ST_FULL)) |-> (element_count == ECNT_W'(CAPACITY))
  ) else $error("full status with spare room");

  // read data is zero unless the status is ok
  a_read_zero: assert property (
    @(posedge clk) disable iff (rst)
    (rsp_valid && (status != ST_OK)) |-> (read_value == '0)
  ) else $error("read data on a failed request");

endmodule

### hdl/olist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module olist_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int AWIDTH = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AWIDTH-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [AWIDTH-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/olist_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_seq
// Request sequencer: decodes a request, walks the value memory (shift up,
// shift down, scan) and holds the count and the finished result.
// ----------------------------------------------------------------------------
module olist_seq import olist_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  input  logic        take,
  output seq_flags_t  flags,
  output res_t        rslt
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_INS_PUT,
    S_SHIFT_DN,
    S_GET_WAIT,
    S_FIND_SCAN,
    S_DONE
  } state_t;

  state_t                  state;
  op_t                     op_r;
  logic [POS_W-1:0]        pos_r;
  logic [VAL_W-1:0]        val_r;
  logic [CNT_W-1:0]        cnt;
  logic [ADDR_W-1:0]       ptr;
  logic [STAT_W-1:0]       status_r;
  logic [VAL_W-1:0]        rdval_r;
  logic [ADDR_W-1:0]       fpos_r;

  // memory port signals
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [VAL_W-1:0]        wr_data;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic [VAL_W-1:0]        rd_data;

  // decode helpers
  logic [CMP_W-1:0]        pos_c;
  logic [CMP_W-1:0]        cnt_c;
  logic                    pos_gt_cnt;
  logic                    pos_ge_cnt;
  logic                    pos_eq_cnt;
  logic                    is_full;
  logic                    is_empty;
  logic [ADDR_W-1:0]       pos_a;
  logic [ADDR_W-1:0]       last_a;
  logic                    pos_is_last;
  logic                    ptr_at_pos;
  logic                    ptr_at_last;
  logic                    hit;

  olist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // position checks against the count
  assign pos_c       = CMP_W'(pos_r);
  assign cnt_c       = CMP_W'(cnt);
  assign pos_gt_cnt  = pos_c > cnt_c;
  assign pos_ge_cnt  = pos_c >= cnt_c;
  assign pos_eq_cnt  = pos_c == cnt_c;
  assign is_full     = cnt == CNT_W'(CAPACITY);
  assign is_empty    = cnt == '0;
  assign pos_a       = ADDR_W'(pos_r);
  assign last_a      = ADDR_W'(cnt - CNT_W'(1));
  assign pos_is_last = pos_a == last_a;
  assign ptr_at_pos  = ptr == pos_a;
  assign ptr_at_last = ptr == last_a;
  assign hit         = rd_data == val_r;

  // memory port drive
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = ptr;
    case (state)
      S_DECODE: begin
        case (op_r)
          OP_INSERT: begin
            if (!pos_gt_cnt && !is_full) begin
              if (pos_eq_cnt) begin
                wr_en   = 1'b1;
                wr_addr = pos_a;
                wr_data = val_r;
              end else begin
                rd_en   = 1'b1;
                rd_addr = last_a;
              end
            end
          end
          OP_REMOVE: begin
            if (!pos_ge_cnt && !pos_is_last) begin
              rd_en   = 1'b1;
              rd_addr = pos_a + ADDR_W'(1);
            end
          end
          OP_GET: begin
            if (!pos_ge_cnt) begin
              rd_en   = 1'b1;
              rd_addr = pos_a;
            end
          end
          OP_FIND: begin
            if (!is_empty) begin
              rd_en   = 1'b1;
              rd_addr = '0;
            end
          end
          OP_UPDATE: begin
            if (!pos_ge_cnt) begin
              wr_en   = 1'b1;
              wr_addr = pos_a;
              wr_data = val_r;
            end
          end
          default: ;
        endcase
      end
      // entry ptr moves up by one; next read is the entry below
      S_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = ptr + ADDR_W'(1);
        if (!ptr_at_pos) begin
          rd_en   = 1'b1;
          rd_addr = ptr - ADDR_W'(1);
        end
      end
      S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_a;
        wr_data = val_r;
      end
      // entry ptr moves down by one; next read is the entry above
      S_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = ptr - ADDR_W'(1);
        if (!ptr_at_last) begin
          rd_en   = 1'b1;
          rd_addr = ptr + ADDR_W'(1);
        end
      end
      S_FIND_SCAN: begin
        if (!hit && !ptr_at_last) begin
          rd_en   = 1'b1;
          rd_addr = ptr + ADDR_W'(1);
        end
      end
      default: ;
    endcase
  end

  // state, count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r  <= op_t'(req.op);
            pos_r <= req.position;
            val_r <= req.value;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          status_r <= ST_OK;
          rdval_r  <= '0;
          fpos_r   <= '0;
          state    <= S_DONE;
          case (op_r)
            OP_INSERT: begin
              if (pos_gt_cnt) begin
                status_r <= ST_BAD_POS;
              end else if (is_full) begin
                status_r <= ST_FULL;
              end else if (pos_eq_cnt) begin
                cnt <= cnt + CNT_W'(1);
              end else begin
                ptr   <= last_a;
                state <= S_SHIFT_UP;
              end
            end
            OP_REMOVE: begin
              if (pos_ge_cnt) begin
                status_r <= ST_BAD_POS;
              end else if (pos_is_last) begin
                cnt <= cnt - CNT_W'(1);
              end else begin
                ptr   <= pos_a + ADDR_W'(1);
                state <= S_SHIFT_DN;
              end
            end
            OP_GET: begin
              if (pos_ge_cnt) begin
                status_r <= ST_BAD_POS;
              end else begin
                state <= S_GET_WAIT;
              end
            end
            OP_FIND: begin
              if (is_empty) begin
                status_r <= ST_NOT_FOUND;
              end else begin
                ptr   <= '0;
                state <= S_FIND_SCAN;
              end
            end
            OP_UPDATE: begin
              if (pos_ge_cnt) begin
                status_r <= ST_BAD_POS;
              end
            end
            OP_CLEAR: begin
              cnt <= '0;
            end
            default: ;
          endcase
        end
        S_SHIFT_UP: begin
          if (ptr_at_pos) begin
            state <= S_INS_PUT;
          end else begin
            ptr <= ptr - ADDR_W'(1);
          end
        end
        S_INS_PUT: begin
          cnt   <= cnt + CNT_W'(1);
          state <= S_DONE;
        end
        S_SHIFT_DN: begin
          if (ptr_at_last) begin
            cnt   <= cnt - CNT_W'(1);
            state <= S_DONE;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_GET_WAIT: begin
          rdval_r <= rd_data;
          state   <= S_DONE;
        end
        // compare the word read for ptr; stop at first hit or at the end
        S_FIND_SCAN: begin
          if (hit) begin
            fpos_r <= ptr;
            state  <= S_DONE;
          end else if (ptr_at_last) begin
            status_r <= ST_NOT_FOUND;
            state    <= S_DONE;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign flags.idle = state == S_IDLE;
  assign flags.done = state == S_DONE;

  assign rslt.status         = status_r;
  assign rslt.read_value     = rdval_r;
  assign rslt.found_position = FPOS_W'(fpos_r);
  assign rslt.element_count  = ECNT_W'(cnt);

endmodule
